// ----- hdl/lr_pkg.sv -----
package lr_pkg;

  // Fixed widths of the register map and of the word fields.
  localparam int unsigned TLEN_W   = 11;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_SAMPLES = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_MAX_TARGET  = 1024;

  // Configuration port geometry.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register index of target_length, taken from paddr above the byte offset.
  localparam logic [APB_AW-3:0] REG_TARGET_LENGTH = '0;

  // Reset value of target_length.
  localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(1);

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_CLEAR = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_LOAD  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_EMIT  = CMD_W'(2);

  // Depth of the queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation held in the queue after classification.
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_EMIT
  } op_e;

  // Status codes of a result word.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_DATA = 2'd1,
    STAT_TRUNC   = 2'd2
  } status_e;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_DIV1,
    BS_READ,
    BS_PREP,
    BS_DIV2GO,
    BS_DIV2,
    BS_FINISH
  } back_state_e;

endpackage

// ----- hdl/lr_front.sv -----
module lr_front #(
  parameter int unsigned SAMPLE_BITS = lr_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lr_pkg::CMD_W-1:0]      cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output lr_pkg::op_e                   op_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  logic keep_w;

  // Decode the command; unused codes are accepted and dropped here.
  always_comb begin
    op_o   = lr_pkg::OP_CLEAR;
    keep_w = 1'b0;
    case (cmd_i)
      lr_pkg::CMD_CLEAR: begin
        op_o   = lr_pkg::OP_CLEAR;
        keep_w = 1'b1;
      end
      lr_pkg::CMD_LOAD: begin
        op_o   = lr_pkg::OP_LOAD;
        keep_w = 1'b1;
      end
      lr_pkg::CMD_EMIT: begin
        op_o   = lr_pkg::OP_EMIT;
        keep_w = 1'b1;
      end
      default: begin
        op_o   = lr_pkg::OP_CLEAR;
        keep_w = 1'b0;
      end
    endcase
  end

  // The front stalls only when the queue has no free entry.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep_w;
  assign sample_o   = sample_i;

endmodule

// ----- hdl/lr_queue.sv -----
module lr_queue #(
  parameter int unsigned WIDTH = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned DEPTH = lr_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push_w, do_pop_w;

  assign full_o    = (32'(count_q) == 32'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign do_push_w = push_i && !full_o;
  assign do_pop_w  = pop_i && valid_o;
  assign data_o    = entry_q[rd_ptr_q];

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push_w) begin
      wr_ptr_d = (32'(wr_ptr_q) == 32'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop_w) begin
      rd_ptr_d = (32'(rd_ptr_q) == 32'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push_w && !do_pop_w) begin
      count_d = count_q + CW'(1);
    end else if (!do_push_w && do_pop_w) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push_w) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/lr_div.sv -----
module lr_div #(
  parameter int unsigned DW = 18,
  parameter int unsigned VW = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [VW-1:0]             divisor_i,
  input  logic [VW-1:0]             rem_init_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [$clog2(DW+1)-1:0]   nbits_i,
  output logic                      busy_o,
  output logic [DW-1:0]             quo_o,
  output logic [VW-1:0]             rem_o
);

  localparam int unsigned NB_W = $clog2(DW + 1);

  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;
  logic [DW-1:0]   dvd_q;
  logic [DW-1:0]   quo_q;
  logic [NB_W-1:0] cnt_q;
  logic            busy_q;
  logic [VW:0]     sh_w;
  logic [VW:0]     diff_w;
  logic            ge_w;

  // One restoring step: bring in the next dividend bit and try a subtract.
  assign sh_w   = {rem_q, dvd_q[DW-1]};
  assign diff_w = sh_w - {1'b0, dvs_q};
  assign ge_w   = (sh_w >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - NB_W'(1);
      if (cnt_q == NB_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The remainder starts preloaded with the high part of the dividend, which
  // is known to be below the divisor, so only the quotient bits are iterated.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dvs_q <= divisor_i;
      dvd_q <= dividend_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge_w ? diff_w[VW-1:0] : sh_w[VW-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DW-2:0], ge_w};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/lr_back.sv -----
module lr_back #(
  parameter int unsigned MAX_SAMPLES = lr_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned SAMPLE_BITS = lr_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned MAX_TARGET  = lr_pkg::DEF_MAX_TARGET
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  lr_pkg::op_e                     q_op_i,
  input  logic signed [SAMPLE_BITS-1:0]   q_sample_i,
  output logic                            q_pop_o,
  input  logic [lr_pkg::TLEN_W-1:0]       target_length_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]   value_o,
  output logic                            last_o,
  output logic [lr_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned TW    = lr_pkg::TLEN_W;
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW    = $clog2(MAX_SAMPLES);
  localparam int unsigned IDX_W = $clog2(MAX_TARGET);
  localparam int unsigned NUM_W = IDX_W + CNT_W;
  localparam int unsigned VW    = TW + 1;
  localparam int unsigned Q2    = SB + 2;
  localparam int unsigned DW    = (CNT_W > Q2) ? CNT_W : Q2;
  localparam int unsigned NB_W  = $clog2(DW + 1);
  localparam int unsigned P_W   = SB + TW + 2;
  localparam int unsigned X_W   = P_W + 2;
  localparam int unsigned Y_W   = X_W + 1;

  lr_pkg::back_state_e state_q, state_d;

  // Architectural state.
  logic [CNT_W-1:0]      count_q;
  logic [IDX_W-1:0]      oidx_q;
  logic                  trunc_q;
  logic signed [SB-1:0]  store_q [MAX_SAMPLES];

  // Per-emit working registers.
  logic [TW-1:0]         den_q;
  logic [CNT_W-1:0]      n1_q;
  logic [NUM_W-1:0]      num_q;
  logic [TW-1:0]         rem_q;
  logic                  single_q;
  logic                  elast_q;
  lr_pkg::status_e       estat_q;
  logic signed [SB-1:0]  rd_a_q, rd_b_q;
  logic signed [P_W-1:0] p_q;
  logic [Y_W-1:0]        y_q;
  logic                  neg_q;

  // Output register.
  logic                  out_valid_q;
  logic signed [SB-1:0]  value_q;
  logic                  last_q;
  lr_pkg::status_e       status_q;

  // Decoded controls from the sequencer.
  logic                  do_clear_w, do_load_w, do_emit_w;
  logic                  rd_en_w, p_en_w, y_en_w;
  logic                  div_start_w, div_sel2_w;
  logic                  out_load_w;
  logic                  out_free_w;
  logic [AW-1:0]         addr_a_w, addr_b_w;
  logic signed [SB-1:0]  out_value_w;
  logic                  out_last_w;
  lr_pkg::status_e       out_status_w;

  // Emit setup values.
  logic [TW-1:0]         m_w;
  logic [TW-1:0]         den_w;
  logic [IDX_W-1:0]      i_w;
  logic [IDX_W-1:0]      inext_w;
  logic [CNT_W-1:0]      n1_w;
  logic                  last_w;
  logic                  single_w;
  logic                  full_w;

  // Divider connections.
  logic                  div_busy_w;
  logic [DW-1:0]         div_quo_w;
  logic [VW-1:0]         div_rem_w;
  logic [VW-1:0]         div_dvs_w;
  logic [VW-1:0]         div_rinit_w;
  logic [DW-1:0]         div_dvd_w;
  logic [NB_W-1:0]       div_nbits_w;

  // Datapath between the stages.
  logic [CNT_W-1:0]      idx_w;
  logic                  big_w;
  logic signed [SB:0]    diff_w;
  logic signed [TW:0]    remx_w;
  logic signed [P_W-1:0] p_w;
  logic [VW-1:0]         d2_w;
  logic signed [X_W-1:0] x_w;
  logic signed [X_W-1:0] xneg_w;
  logic [X_W-1:0]        xmag_w;
  logic [Y_W-1:0]        y_w;
  logic [Q2-1:0]         q2_w;
  logic signed [SB+2:0]  qs_w;
  logic signed [SB+2:0]  sum_w;

  assign full_w     = (32'(count_q) >= 32'(MAX_SAMPLES));
  assign out_free_w = !out_valid_q || !out_stall_i;

  // Effective point count, stale-index restart and next index.
  always_comb begin
    if (target_length_i == '0) begin
      m_w = TW'(1);
    end else if (32'(target_length_i) > 32'(MAX_TARGET)) begin
      m_w = TW'(MAX_TARGET);
    end else begin
      m_w = target_length_i;
    end
  end

  assign den_w    = m_w - TW'(1);
  assign i_w      = (32'(oidx_q) >= 32'(m_w)) ? '0 : oidx_q;
  assign inext_w  = ((32'(i_w) + 32'd1) >= 32'(m_w)) ? '0 : IDX_W'(32'(i_w) + 32'd1);
  assign n1_w     = count_q - CNT_W'(1);
  assign last_w   = (32'(i_w) == 32'(den_w));
  assign single_w = (den_w == '0) || (n1_w == '0);

  // Position quotient and the neighbor pair it selects.
  assign idx_w = div_quo_w[CNT_W-1:0];
  assign big_w = (idx_w >= n1_q);

  // Weighted difference and the rounding dividend.
  assign diff_w = (SB+1)'(rd_b_q) - (SB+1)'(rd_a_q);
  assign remx_w = {1'b0, rem_q};
  assign p_w    = P_W'(diff_w) * P_W'(remx_w);
  assign d2_w   = {den_q, 1'b0};
  assign x_w    = (X_W'(p_q) <<< 1) + X_W'($signed({1'b0, den_q}));
  assign xneg_w = -x_w;
  assign xmag_w = x_w[X_W-1] ? $unsigned(xneg_w) : $unsigned(x_w);
  assign y_w    = x_w[X_W-1] ? (Y_W'(xmag_w) + Y_W'(d2_w) - Y_W'(1)) : Y_W'(xmag_w);

  // Final value: lower sample plus the signed rounded step.
  assign q2_w  = div_quo_w[Q2-1:0];
  assign qs_w  = neg_q ? -$signed({1'b0, q2_w}) : $signed({1'b0, q2_w});
  assign sum_w = (SB+3)'(rd_a_q) + qs_w;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lr_pkg::BS_IDLE: begin
        if (q_valid_i && (q_op_i == lr_pkg::OP_EMIT) && (count_q != '0)) begin
          state_d = single_w ? lr_pkg::BS_READ : lr_pkg::BS_MUL;
        end
      end
      lr_pkg::BS_MUL: begin
        state_d = lr_pkg::BS_DIV1;
      end
      lr_pkg::BS_DIV1: begin
        if (!div_busy_w) begin
          state_d = lr_pkg::BS_READ;
        end
      end
      lr_pkg::BS_READ: begin
        state_d = single_q ? lr_pkg::BS_FINISH : lr_pkg::BS_PREP;
      end
      lr_pkg::BS_PREP: begin
        state_d = lr_pkg::BS_DIV2GO;
      end
      lr_pkg::BS_DIV2GO: begin
        state_d = lr_pkg::BS_DIV2;
      end
      lr_pkg::BS_DIV2: begin
        if (!div_busy_w) begin
          state_d = lr_pkg::BS_FINISH;
        end
      end
      lr_pkg::BS_FINISH: begin
        if (out_free_w) begin
          state_d = lr_pkg::BS_IDLE;
        end
      end
      default: begin
        state_d = lr_pkg::BS_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop_o      = 1'b0;
    do_clear_w   = 1'b0;
    do_load_w    = 1'b0;
    do_emit_w    = 1'b0;
    rd_en_w      = 1'b0;
    p_en_w       = 1'b0;
    y_en_w       = 1'b0;
    div_start_w  = 1'b0;
    div_sel2_w   = 1'b0;
    out_load_w   = 1'b0;
    addr_a_w     = '0;
    addr_b_w     = '0;
    out_value_w  = '0;
    out_last_w   = 1'b0;
    out_status_w = lr_pkg::STAT_NO_DATA;
    case (state_q)
      lr_pkg::BS_IDLE: begin
        if (q_valid_i) begin
          case (q_op_i)
            lr_pkg::OP_CLEAR: begin
              q_pop_o    = 1'b1;
              do_clear_w = 1'b1;
            end
            lr_pkg::OP_LOAD: begin
              q_pop_o   = 1'b1;
              do_load_w = 1'b1;
            end
            lr_pkg::OP_EMIT: begin
              if (count_q == '0) begin
                // Nothing loaded: report it without touching the index.
                if (out_free_w) begin
                  q_pop_o    = 1'b1;
                  out_load_w = 1'b1;
                end
              end else begin
                q_pop_o   = 1'b1;
                do_emit_w = 1'b1;
                rd_en_w   = single_w;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      lr_pkg::BS_MUL: begin
        div_start_w = 1'b1;
      end
      lr_pkg::BS_DIV1: begin
        if (!div_busy_w) begin
          rd_en_w  = 1'b1;
          addr_a_w = big_w ? AW'(n1_q) : AW'(idx_w);
          addr_b_w = AW'(idx_w + CNT_W'(1));
        end
      end
      lr_pkg::BS_READ: begin
        p_en_w = 1'b1;
      end
      lr_pkg::BS_PREP: begin
        y_en_w = 1'b1;
      end
      lr_pkg::BS_DIV2GO: begin
        div_start_w = 1'b1;
        div_sel2_w  = 1'b1;
      end
      lr_pkg::BS_DIV2: begin
        div_sel2_w = 1'b1;
      end
      lr_pkg::BS_FINISH: begin
        out_load_w   = out_free_w;
        out_value_w  = single_q ? rd_a_q : SB'(sum_w);
        out_last_w   = elast_q;
        out_status_w = estat_q;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  // Divider operands: position first, then the rounded step.
  always_comb begin
    if (div_sel2_w) begin
      div_dvs_w   = d2_w;
      div_rinit_w = VW'(y_q >> Q2);
      div_dvd_w   = DW'(y_q[Q2-1:0]) << (DW - Q2);
      div_nbits_w = NB_W'(Q2);
    end else begin
      div_dvs_w   = VW'(den_q);
      div_rinit_w = VW'(num_q >> CNT_W);
      div_dvd_w   = DW'(num_q[CNT_W-1:0]) << (DW - CNT_W);
      div_nbits_w = NB_W'(CNT_W);
    end
  end

  lr_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_w),
    .divisor_i  (div_dvs_w),
    .rem_init_i (div_rinit_w),
    .dividend_i (div_dvd_w),
    .nbits_i    (div_nbits_w),
    .busy_o     (div_busy_w),
    .quo_o      (div_quo_w),
    .rem_o      (div_rem_w)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lr_pkg::BS_IDLE;
      count_q     <= '0;
      oidx_q      <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_clear_w) begin
        count_q <= '0;
        oidx_q  <= '0;
        trunc_q <= 1'b0;
      end
      if (do_load_w) begin
        if (full_w) begin
          trunc_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (do_emit_w) begin
        oidx_q <= inext_w;
      end
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of one emit.
  always_ff @(posedge clk_i) begin
    if (do_emit_w) begin
      den_q    <= den_w;
      n1_q     <= n1_w;
      num_q    <= NUM_W'(i_w) * NUM_W'(n1_w);
      single_q <= single_w;
      elast_q  <= last_w;
      estat_q  <= trunc_q ? lr_pkg::STAT_TRUNC : lr_pkg::STAT_OK;
    end
    if ((state_q == lr_pkg::BS_DIV1) && !div_busy_w) begin
      rem_q    <= TW'(div_rem_w);
      single_q <= big_w;
    end
    if (p_en_w) begin
      p_q <= p_w;
    end
    if (y_en_w) begin
      y_q   <= y_w;
      neg_q <= x_w[X_W-1];
    end
    if (out_load_w) begin
      value_q  <= out_value_w;
      last_q   <= out_last_w;
      status_q <= out_status_w;
    end
  end

  // Sample store with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (do_load_w && !full_w) begin
      store_q[AW'(count_q)] <= q_sample_i;
    end
    if (rd_en_w) begin
      rd_a_q <= store_q[addr_a_w];
      rd_b_q <= store_q[addr_b_w];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

// ----- hdl/linear_resampler.sv -----
// Channel  Dir  Handshake                   Fields
// in       in   in_valid_i / in_stall_o     cmd_i, sample_i
// out      out  out_valid_o / out_stall_i   value_o, last_o, status_o
// cfg      in   psel, penable, pready       target_length at byte address 0
//
// Clear and load are each handled in the back end's idle state, and so is an
// emit with no samples loaded. An emit with data runs the shared bit-serial
// divider once for the position and once more for the rounded step. The last
// point skips the second pass, and a single sample or a single point skips
// both. An output stall holds the back end in its final state. Reset clears
// the counts, the index, the flag and the queue.
module linear_resampler #(
  parameter int unsigned MAX_SAMPLES = lr_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned SAMPLE_BITS = lr_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned MAX_TARGET  = lr_pkg::DEF_MAX_TARGET
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lr_pkg::CMD_W-1:0]      cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic                          last_o,
  output logic [lr_pkg::STATUS_W-1:0]   status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lr_pkg::APB_AW-1:0]     paddr,
  input  logic [lr_pkg::APB_DW-1:0]     pwdata,
  output logic [lr_pkg::APB_DW-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned OPW = $bits(lr_pkg::op_e);
  localparam int unsigned QW  = OPW + SAMPLE_BITS;

  logic [lr_pkg::TLEN_W-1:0]   tlen_q;
  logic                        reg_sel_w;
  logic                        push_w;
  logic                        q_full_w;
  logic                        q_valid_w;
  logic                        q_pop_w;
  lr_pkg::op_e                 fr_op_w;
  logic signed [SAMPLE_BITS-1:0] fr_sample_w;
  logic [QW-1:0]               q_data_w;
  lr_pkg::op_e                 q_op_w;
  logic signed [SAMPLE_BITS-1:0] q_sample_w;

  // Configuration register.
  assign pready    = 1'b1;
  assign reg_sel_w = (paddr[lr_pkg::APB_AW-1:2] == lr_pkg::REG_TARGET_LENGTH);
  assign prdata    = reg_sel_w ? lr_pkg::APB_DW'(tlen_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q <= lr_pkg::TLEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel_w) begin
      tlen_q <= pwdata[lr_pkg::TLEN_W-1:0];
    end
  end

  lr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .q_full_i   (q_full_w),
    .push_o     (push_w),
    .op_o       (fr_op_w),
    .sample_o   (fr_sample_w)
  );

  lr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .data_i  ({fr_op_w, fr_sample_w}),
    .full_o  (q_full_w),
    .valid_o (q_valid_w),
    .pop_i   (q_pop_w),
    .data_o  (q_data_w)
  );

  assign q_op_w     = lr_pkg::op_e'(q_data_w[QW-1 -: OPW]);
  assign q_sample_w = q_data_w[SAMPLE_BITS-1:0];

  lr_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TARGET  (MAX_TARGET)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid_w),
    .q_op_i          (q_op_w),
    .q_sample_i      (q_sample_w),
    .q_pop_o         (q_pop_w),
    .target_length_i (tlen_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .value_o         (value_o),
    .last_o          (last_o),
    .status_o        (status_o)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_w |-> !q_full_w)
    else $error("push into a full queue");

  // The back end only pops a word that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_w |-> q_valid_w)
    else $error("pop from an empty queue");

  // A no-data report carries a zero value and is never the last point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == lr_pkg::STAT_NO_DATA)) |-> ((value_o == '0) && !last_o))
    else $error("no-data word with a nonzero payload");

endmodule
